### sv/bfca_pkg.sv
// ---------------------------------------------------------------------------
// bfca_pkg
// Shared constants, codes and types of the best-fit capacity allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bfca_pkg;

   localparam int FLOORS     = 16;
   localparam int CAP_BITS   = 16;
   localparam int POOL_W     = 5;
   localparam int TOT_W      = 20;
   localparam int UNITS_W    = 16;
   localparam int DEMAND_W   = 20;
   localparam int CAPIN_W    = 16;

   localparam int IDX_W      = (FLOORS > 1) ? $clog2(FLOORS) : 1;
   localparam int CNT_W      = $clog2(FLOORS + 1);
   localparam int CMP_W      = (TOT_W > CAP_BITS) ? TOT_W : CAP_BITS;
   localparam int SUM_W      = CMP_W + 1;

   // request beat: pool_number, pool_capacity, demand from bit 0 up
   localparam int REQ_FIELDS_W = POOL_W + CAPIN_W + DEMAND_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = POOL_W + UNITS_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_BOOK    = 1'b1;
   localparam logic STAT_ENTRY  = 1'b0;
   localparam logic STAT_REJECT = 1'b1;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CAP_BITS-1:0] cap_type;
   typedef logic [TOT_W-1:0]    tot_type;

   typedef struct packed {
      logic    clear;
      logic    vld;
      idx_type idx;
      cap_type cap;
   } scan_beat_type;

   typedef struct packed {
      logic    fit_found;
      idx_type idx;
      cap_type cap;
   } scan_sel_type;

endpackage

`default_nettype wire

### sv/best_fit_capacity_allocator_core.sv
// ---------------------------------------------------------------------------
// best_fit_capacity_allocator_core
// Pool capacity store with best-fit splitting of bookings over the pools.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries load and booking beats (req_tuser 0 = load, 1 = booking).
//   A load gives no response. A booking that exceeds the running total, or
//   that finds every pool empty, gives one rejected beat (rsp_tuser 1).
//   Otherwise one rsp beat per pool used comes out in ascending pool order,
//   rsp_tlast on the final one. A booking of 0 is dropped.
//   Each selection pass reads the capacity memory once per pool through
//   its single read port and then writes back the chosen pool, up to
//   FLOORS passes; the readout then walks the booking memory.
//   One item is in work at a time; req_tready is high only while idle.
//   The response sits in an output register, so loads keep flowing while a
//   beat waits; a stalled receiver holds the readout walk in place.
//   Reset empties all pools and the total at once through per-entry valid
//   bits; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module best_fit_capacity_allocator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pool_number [4:0], pool_capacity [20:5], demand [40:21]
   input  logic [bfca_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // assigned_pool [4:0], units_booked [20:5]
   output logic [bfca_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [0:0]                         rsp_tuser,
   output logic                               rsp_tlast
);
   import bfca_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_EMIT_RD,
      ST_EMIT_WR,
      ST_REJECT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   pass_ff, pass_in;
   tot_type            outstanding_ff, outstanding_in;
   tot_type            total_ff, total_in;
   idx_type            last_idx_ff, last_idx_in;
   logic               any_ff, any_in;
   logic               rd_vld_ff, rd_vld_in;
   idx_type            rd_idx_ff, rd_idx_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_status_ff, out_status_in;
   logic [POOL_W-1:0]  out_pool_ff, out_pool_in;
   logic [UNITS_W-1:0] out_units_ff, out_units_in;
   logic               out_last_ff, out_last_in;

   cap_type            cap_mem [FLOORS];
   logic               cap_vbit_ff [FLOORS];
   cap_type            book_mem [FLOORS];
   logic               book_flag_ff [FLOORS];
   cap_type            cap_rd_ff;
   logic               cap_rd_vbit_ff;
   cap_type            book_rd_ff;

   logic               cap_we;
   idx_type            cap_waddr;
   cap_type            cap_wdata;
   logic               book_we;
   logic               book_clear;
   idx_type            rd_addr;

   logic [POOL_W-1:0]   req_pool;
   logic [CAPIN_W-1:0]  req_cap_raw;
   logic [DEMAND_W-1:0] req_demand;
   logic                accept;
   logic                slot_free;
   logic                pool_ok;
   idx_type             load_idx;
   cap_type             cap_in_val;
   logic [SUM_W-1:0]    sum;
   tot_type             total_sat;
   cap_type             take;
   tot_type             out_left;
   logic [CNT_W-1:0]    pass_next;
   logic [IDX_W:0]      pool_num;
   logic                scan_start;
   scan_beat_type       scan_beat;
   scan_sel_type        scan_sel;

   assign req_pool    = req_tdata[POOL_W-1:0];
   assign req_cap_raw = req_tdata[POOL_W+CAPIN_W-1:POOL_W];
   assign req_demand  = req_tdata[REQ_FIELDS_W-1:POOL_W+CAPIN_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !out_valid_ff || rsp_tready;

   assign pool_ok    = (req_pool != '0) && (int'(req_pool) <= FLOORS);
   assign load_idx   = IDX_W'(req_pool - 5'd1);
   assign cap_in_val = CAP_BITS'(req_cap_raw);
   assign sum        = SUM_W'(total_ff) + SUM_W'(cap_in_val);
   assign total_sat  = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOT_W'(sum);

   assign rd_addr    = (cnt_ff < CNT_W'(FLOORS)) ? cnt_ff[IDX_W-1:0] : '0;
   assign pool_num   = {1'b0, rd_addr} + 1'b1;
   assign pass_next  = pass_ff + 1'b1;

   // the amount taken from the chosen pool never exceeds what is outstanding (the min)
   assign take     = (CMP_W'(scan_sel.cap) < CMP_W'(outstanding_ff)) ?
                     scan_sel.cap : CAP_BITS'(outstanding_ff);
   assign out_left = outstanding_ff - TOT_W'(take);

   assign scan_beat.clear = scan_start;
   assign scan_beat.vld   = rd_vld_ff;
   assign scan_beat.idx   = rd_idx_ff;
   assign scan_beat.cap   = cap_rd_vbit_ff ? cap_rd_ff : '0;

   bfca_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .beat        (scan_beat),
      .outstanding (outstanding_ff),
      .sel         (scan_sel)
   );

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      pass_in        = pass_ff;
      outstanding_in = outstanding_ff;
      total_in       = total_ff;
      last_idx_in    = last_idx_ff;
      any_in         = any_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_addr;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_status_in  = out_status_ff;
      out_pool_in    = out_pool_ff;
      out_units_in   = out_units_ff;
      out_last_in    = out_last_ff;
      cap_we         = 1'b0;
      cap_waddr      = load_idx;
      cap_wdata      = cap_in_val;
      book_we        = 1'b0;
      book_clear     = 1'b0;
      scan_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0] == REQ_LOAD) begin
                  if (pool_ok) begin
                     cap_we   = 1'b1;
                     total_in = total_sat;
                  end
               end else if (req_demand != '0) begin
                  if (req_demand > total_ff) begin
                     state_in = ST_REJECT;
                  end else begin
                     total_in       = total_ff - req_demand;
                     outstanding_in = req_demand;
                     book_clear     = 1'b1;
                     any_in         = 1'b0;
                     last_idx_in    = '0;
                     pass_in        = '0;
                     cnt_in         = '0;
                     scan_start     = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff < CNT_W'(FLOORS)) begin
               cnt_in    = cnt_ff + 1'b1;
               rd_vld_in = 1'b1;
            end else if (!rd_vld_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cnt_in = '0;
            if (scan_sel.cap == '0) begin
               // every pool is empty
               state_in = any_ff ? ST_EMIT_RD : ST_REJECT;
            end else begin
               cap_we         = 1'b1;
               cap_waddr      = scan_sel.idx;
               cap_wdata      = scan_sel.cap - take;
               book_we        = 1'b1;
               any_in         = 1'b1;
               if (!any_ff || (scan_sel.idx > last_idx_ff)) begin
                  last_idx_in = scan_sel.idx;
               end
               outstanding_in = out_left;
               pass_in        = pass_next;
               if ((out_left == '0) || (pass_next >= CNT_W'(FLOORS))) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_EMIT_RD: begin
            if (cnt_ff >= CNT_W'(FLOORS)) begin
               state_in = ST_IDLE;
            end else if (book_flag_ff[rd_addr]) begin
               state_in = ST_EMIT_WR;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT_WR: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_status_in = STAT_ENTRY;
               out_pool_in   = POOL_W'(pool_num);
               out_units_in  = UNITS_W'(book_rd_ff);
               out_last_in   = (rd_addr == last_idx_ff);
               cnt_in        = cnt_ff + 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
         ST_REJECT: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_status_in = STAT_REJECT;
               out_pool_in   = '0;
               out_units_in  = '0;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pass_ff      <= '0;
         total_ff     <= '0;
         any_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         total_ff     <= total_in;
         any_ff       <= any_in;
         rd_vld_ff    <= rd_vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      outstanding_ff <= outstanding_in;
      last_idx_ff    <= last_idx_in;
      rd_idx_ff      <= rd_idx_in;
      out_status_ff  <= out_status_in;
      out_pool_ff    <= out_pool_in;
      out_units_ff   <= out_units_in;
      out_last_ff    <= out_last_in;
   end

   // capacity memory, an entry without its valid bit reads as empty
   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_waddr] <= cap_wdata;
      end
      cap_rd_ff <= cap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FLOORS; i++) begin
            cap_vbit_ff[i] <= 1'b0;
         end
      end else if (cap_we) begin
         cap_vbit_ff[cap_waddr] <= 1'b1;
      end
      cap_rd_vbit_ff <= cap_vbit_ff[rd_addr];
   end

   // per-booking units, flags cleared when a booking starts
   always_ff @(posedge clock) begin
      if (book_we) begin
         book_mem[scan_sel.idx] <= take;
      end
      book_rd_ff <= book_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || book_clear) begin
         for (int i = 0; i < FLOORS; i++) begin
            book_flag_ff[i] <= 1'b0;
         end
      end else if (book_we) begin
         book_flag_ff[scan_sel.idx] <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_units_ff, out_pool_ff});

endmodule

`default_nettype wire

### sv/bfca_scan.sv
// ---------------------------------------------------------------------------
// bfca_scan
// Running best-fit / largest-pool selection over one pass of capacity reads.
// ---------------------------------------------------------------------------
`default_nettype none

module bfca_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  bfca_pkg::scan_beat_type beat,
   input  bfca_pkg::tot_type      outstanding,
   output bfca_pkg::scan_sel_type sel
);
   import bfca_pkg::*;

   logic    fit_found_ff, fit_found_in;
   logic    big_found_ff, big_found_in;
   idx_type fit_idx_ff, fit_idx_in;
   idx_type big_idx_ff, big_idx_in;
   cap_type fit_cap_ff, fit_cap_in;
   cap_type big_cap_ff, big_cap_in;
   logic    is_fit;
   logic    take_fit;
   logic    take_big;

   assign is_fit   = CMP_W'(beat.cap) >= CMP_W'(outstanding);
   // "<=" and ">=" let the later, higher-numbered pool win ties
   assign take_fit = is_fit && (!fit_found_ff || (beat.cap <= fit_cap_ff));
   assign take_big = !big_found_ff || (beat.cap >= big_cap_ff);

   always_comb begin
      fit_found_in = fit_found_ff;
      big_found_in = big_found_ff;
      fit_idx_in   = fit_idx_ff;
      big_idx_in   = big_idx_ff;
      fit_cap_in   = fit_cap_ff;
      big_cap_in   = big_cap_ff;
      if (beat.clear) begin
         fit_found_in = 1'b0;
         big_found_in = 1'b0;
      end else if (beat.vld) begin
         if (take_fit) begin
            fit_found_in = 1'b1;
            fit_idx_in   = beat.idx;
            fit_cap_in   = beat.cap;
         end
         if (take_big) begin
            big_found_in = 1'b1;
            big_idx_in   = beat.idx;
            big_cap_in   = beat.cap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_found_ff <= 1'b0;
         big_found_ff <= 1'b0;
      end else begin
         fit_found_ff <= fit_found_in;
         big_found_ff <= big_found_in;
      end
   end

   always_ff @(posedge clock) begin
      fit_idx_ff <= fit_idx_in;
      big_idx_ff <= big_idx_in;
      fit_cap_ff <= fit_cap_in;
      big_cap_ff <= big_cap_in;
   end

   assign sel.fit_found = fit_found_ff;
   assign sel.idx       = fit_found_ff ? fit_idx_ff : big_idx_ff;
   assign sel.cap       = fit_found_ff ? fit_cap_ff : big_cap_ff;

endmodule

`default_nettype wire

### sv/bfca_checker.sv
// ---------------------------------------------------------------------------
// bfca_checker
// Port-level checks on the response channel of the allocator core.
// ---------------------------------------------------------------------------
`default_nettype none

module bfca_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bfca_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]                      rsp_tuser,
   input logic                            rsp_tlast
);
   import bfca_pkg::*;

   // a stalled beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // a rejection is a single empty closing beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == STAT_REJECT) |->
         rsp_tlast && (rsp_tdata == '0))
      else $error("rejected beat not empty or not last");

   // a booking entry names a real pool and carries units
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == STAT_ENTRY) |->
         (rsp_tdata[POOL_W-1:0] != '0) && (rsp_tdata[RSP_FIELDS_W-1:POOL_W] != '0))
      else $error("booking entry without pool or units");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind best_fit_capacity_allocator_core bfca_checker u_bfca_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives load and booking beats into the best-fit allocator, predicts the
// per-pool split of every booking and checks each response beat in order.
// ---------------------------------------------------------------------------

module testbench;
   import bfca_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_ITEMS = 400;
   localparam int SHOW_MAX     = 10;
   localparam int PLAN_ROWS    = 26;

   typedef struct packed {
      logic               status;
      logic [POOL_W-1:0]  pool;
      logic [UNITS_W-1:0] units;
      logic               last;
   } grant_type;

   typedef struct {
      logic                kind;
      logic [POOL_W-1:0]   pool;
      logic [CAPIN_W-1:0]  cap;
      logic [DEMAND_W-1:0] demand;
      logic                fixed;
      grant_type           want;
   } plan_row_type;

   localparam grant_type REJECT_BEAT = '{STAT_REJECT, 5'd0, 16'd0, 1'b1};
   localparam grant_type NO_BEAT     = '0;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;

   // allocator state as predicted
   logic [CAP_BITS-1:0] pool_left [FLOORS];
   logic [TOT_W-1:0]    units_free;
   grant_type           fresh[$];
   grant_type           grants_due[$];

   plan_row_type plan [PLAN_ROWS];
   bit        calm;
   int        errors, shown;
   int        loads, saturations, bookings, rejects, dry_runs, widest, beats_seen;

   best_fit_capacity_allocator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("** best_fit_capacity_allocator_core: FAILED **");
      $finish;
   end

   // apply one item to the pool store and fill fresh with the beats it causes
   function automatic void allocate(input logic kind, input logic [POOL_W-1:0] pool,
                                    input logic [CAPIN_W-1:0] cap,
                                    input logic [DEMAND_W-1:0] demand);
      logic [TOT_W:0]      sum;
      logic [TOT_W-1:0]    owed;
      logic [CAP_BITS-1:0] booked [FLOORS];
      logic [CAP_BITS-1:0] take;
      int                  fit, big, top, pass, i;
      grant_type           g;
      fresh.delete();
      if (kind == REQ_LOAD) begin
         if (pool >= 1 && pool <= FLOORS) begin
            sum = units_free + cap[CAP_BITS-1:0];
            pool_left[pool-1] = cap[CAP_BITS-1:0];
            if (sum > TOTAL_MAX) begin
               units_free = TOTAL_MAX;
               saturations++;
            end else begin
               units_free = sum[TOT_W-1:0];
            end
            loads++;
         end
         return;
      end
      if (demand == 0) return;
      bookings++;
      if (demand > units_free) begin
         fresh = {fresh, REJECT_BEAT};
         rejects++;
         return;
      end
      units_free = units_free - demand;
      owed = demand;
      for (i = 0; i < FLOORS; i++) booked[i] = '0;
      for (pass = 0; pass < FLOORS && owed != 0; pass++) begin
         fit = -1;
         big = -1;
         for (i = 0; i < FLOORS; i++) begin
            // smallest pool that covers the rest, largest as fallback, ties high
            if (pool_left[i] >= owed && (fit < 0 || pool_left[i] <= pool_left[fit]))
               fit = i;
            if (big < 0 || pool_left[i] >= pool_left[big])
               big = i;
         end
         if (fit < 0) fit = big;
         if (pool_left[fit] == 0) break;
         take = (pool_left[fit] < owed) ? pool_left[fit] : owed[CAP_BITS-1:0];
         pool_left[fit] = pool_left[fit] - take;
         booked[fit] = booked[fit] + take;
         owed = owed - take;
      end
      if (owed != 0) dry_runs++;
      top = -1;
      for (i = 0; i < FLOORS; i++)
         if (booked[i] != 0) top = i;
      if (top < 0) begin
         fresh = {fresh, REJECT_BEAT};
         rejects++;
         return;
      end
      for (i = 0; i < FLOORS; i++) begin
         if (booked[i] != 0) begin
            g.status = STAT_ENTRY;
            g.pool   = POOL_W'(i + 1);
            g.units  = booked[i];
            g.last   = (i == top);
            fresh = {fresh, g};
         end
      end
      if (fresh.size() > widest) widest = fresh.size();
   endfunction

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 99) < 11) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
   endtask

   task automatic hold_req_low();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_beat(input logic kind, input logic [POOL_W-1:0] pool,
                            input logic [CAPIN_W-1:0] cap,
                            input logic [DEMAND_W-1:0] demand,
                            input logic fixed, input grant_type want);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = REQ_DATA_W'({demand, cap, pool});
      do @(posedge clock); while (!req_tready);
      allocate(kind, pool, cap, demand);
      if (fixed)
         grants_due = {grants_due, want};
      else
         foreach (fresh[i]) grants_due = {grants_due, fresh[i]};
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = calm || ($urandom_range(0, 99) >= 11);
      end
   end

   // response beat checker
   always @(posedge clock) begin
      grant_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser[0], rsp_tdata[POOL_W-1:0],
                 rsp_tdata[POOL_W+UNITS_W-1:POOL_W], rsp_tlast};
         beats_seen++;
         if (grants_due.size() == 0) begin
            errors++;
            if (shown < SHOW_MAX) begin
               shown++;
               $display("%0t: unexpected beat status %0d pool %0d units %0d last %0d",
                        $time, got.status, got.pool, got.units, got.last);
            end
         end else begin
            want = grants_due.pop_front();
            if (got.status != want.status || got.pool != want.pool ||
                got.units != want.units || got.last != want.last) begin
               errors++;
               if (shown < SHOW_MAX) begin
                  shown++;
                  $display("%0t: expected status %0d pool %0d units %0d last %0d",
                           $time, want.status, want.pool, want.units, want.last);
                  $display("%0t:      got status %0d pool %0d units %0d last %0d",
                           $time, got.status, got.pool, got.units, got.last);
               end
            end
         end
      end
   end

   initial begin
      logic [POOL_W-1:0]   pool;
      logic [CAPIN_W-1:0]  cap;
      logic [DEMAND_W-1:0] demand;
      int                  counted, pick, p;
      bit                  held;

      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      reset      = 1'b1;
      calm       = 1'b0;
      foreach (pool_left[i]) pool_left[i] = '0;
      units_free = '0;

      plan = '{
         // nothing loaded yet
         '{REQ_BOOK, 5'd0,  16'd0,     20'd5,       1'b1, REJECT_BEAT},
         '{REQ_BOOK, 5'd0,  16'd0,     20'd0,       1'b0, NO_BEAT},
         // pool numbers out of range are dropped
         '{REQ_LOAD, 5'd0,  16'd100,   20'd0,       1'b0, NO_BEAT},
         '{REQ_LOAD, 5'd17, 16'd100,   20'd0,       1'b0, NO_BEAT},
         '{REQ_LOAD, 5'd31, 16'hFFFF,  20'd0,       1'b0, NO_BEAT},
         '{REQ_BOOK, 5'd31, 16'hFFFF,  20'd1,       1'b1, REJECT_BEAT},
         '{REQ_LOAD, 5'd1,  16'hFFFF,  20'd0,       1'b0, NO_BEAT},
         '{REQ_BOOK, 5'd0,  16'd0,     20'hFFFF,    1'b1,
           '{STAT_ENTRY, 5'd1, 16'hFFFF, 1'b1}},
         '{REQ_LOAD, 5'd16, 16'd0,     20'hFFFFF,   1'b0, NO_BEAT},
         '{REQ_BOOK, 5'd0,  16'd0,     20'd1,       1'b1, REJECT_BEAT},
         '{REQ_LOAD, 5'd3,  16'd500,   20'd0,       1'b0, NO_BEAT},
         '{REQ_LOAD, 5'd7,  16'd300,   20'd0,       1'b0, NO_BEAT},
         '{REQ_LOAD, 5'd12, 16'd300,   20'd0,       1'b0, NO_BEAT},
         // equal fits, higher pool wins
         '{REQ_BOOK, 5'd0,  16'd0,     20'd300,     1'b1,
           '{STAT_ENTRY, 5'd12, 16'd300, 1'b1}},
         '{REQ_BOOK, 5'd0,  16'd0,     20'd700,     1'b0, NO_BEAT},
         // reload adds to the total without taking the old capacity back
         '{REQ_LOAD, 5'd5,  16'd400,   20'd0,       1'b0, NO_BEAT},
         '{REQ_LOAD, 5'd5,  16'd1000,  20'd0,       1'b0, NO_BEAT},
         '{REQ_BOOK, 5'd0,  16'd0,     20'd1200,    1'b0, NO_BEAT},
         // total left over but every pool empty
         '{REQ_BOOK, 5'd0,  16'd0,     20'd300,     1'b1, REJECT_BEAT},
         '{REQ_LOAD, 5'd2,  16'hFFFF,  20'd0,       1'b0, NO_BEAT},
         '{REQ_LOAD, 5'd9,  16'hAAAA,  20'd0,       1'b0, NO_BEAT},
         '{REQ_LOAD, 5'd10, 16'h5555,  20'd0,       1'b0, NO_BEAT},
         '{REQ_BOOK, 5'd0,  16'd0,     20'h1FFFE,   1'b0, NO_BEAT},
         '{REQ_BOOK, 5'd0,  16'd0,     20'h80000,   1'b1, REJECT_BEAT},
         '{REQ_LOAD, 5'd16, 16'h1234,  20'd0,       1'b0, NO_BEAT},
         '{REQ_BOOK, 5'd0,  16'd0,     20'h1234,    1'b1,
           '{STAT_ENTRY, 5'd16, 16'h1234, 1'b1}}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[r]) begin
         sender_gap();
         send_beat(plan[r].kind, plan[r].pool, plan[r].cap, plan[r].demand,
                   plan[r].fixed, plan[r].want);
      end

      counted = 0;
      held = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         calm = (counted >= 280 && counted < 360);
         if (!held && counted >= 200) begin
            // let the block drain completely before going on
            held = 1'b1;
            hold_req_low();
            while (grants_due.size() != 0) @(posedge clock);
         end
         sender_gap();
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            // flood the pools until the total saturates, then book deep into it
            repeat ($urandom_range(17, 20)) begin
               sender_gap();
               send_beat(REQ_LOAD, POOL_W'($urandom_range(1, FLOORS)), 16'hFFFF,
                         DEMAND_W'($urandom), 1'b0, NO_BEAT);
               counted++;
            end
            sender_gap();
            send_beat(REQ_BOOK, POOL_W'($urandom), CAPIN_W'($urandom),
                      DEMAND_W'($urandom_range(1, units_free)), 1'b0, NO_BEAT);
            counted++;
         end else if (pick < 42) begin
            pool = POOL_W'($urandom_range(1, FLOORS));
            p = $urandom_range(0, 99);
            if (p < 5)       cap = '0;
            else if (p < 40) cap = CAPIN_W'($urandom_range(1, 400));
            else if (p < 75) cap = CAPIN_W'($urandom_range(1, 5000));
            else if (p < 92) cap = CAPIN_W'($urandom);
            else             cap = 16'hFFFF;
            send_beat(REQ_LOAD, pool, cap, DEMAND_W'($urandom), 1'b0, NO_BEAT);
            counted++;
         end else if (pick < 47) begin
            p = $urandom_range(FLOORS, 31);
            pool = (p == FLOORS) ? POOL_W'(0) : POOL_W'(p);
            send_beat(REQ_LOAD, pool, CAPIN_W'($urandom), DEMAND_W'($urandom),
                      1'b0, NO_BEAT);
         end else if (pick < 50) begin
            send_beat(REQ_BOOK, POOL_W'($urandom), CAPIN_W'($urandom), '0,
                      1'b0, NO_BEAT);
         end else begin
            if (pick < 57 && units_free != TOTAL_MAX)
               demand = DEMAND_W'($urandom_range(units_free + 1, TOTAL_MAX));
            else if (units_free == 0)
               demand = DEMAND_W'($urandom);
            else begin
               p = $urandom_range(0, 99);
               if (p < 25)
                  demand = DEMAND_W'($urandom_range(1, (units_free < 300) ? units_free : 300));
               else if (p < 40)
                  demand = units_free;
               else
                  demand = DEMAND_W'($urandom_range(1, units_free));
            end
            send_beat(REQ_BOOK, POOL_W'($urandom), CAPIN_W'($urandom), demand,
                      1'b0, NO_BEAT);
            if (demand != 0) counted++;
         end
      end
      calm = 1'b0;

      hold_req_low();
      while (grants_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d pool loads (%0d into a saturated total), %0d bookings",
               loads, saturations, bookings);
      $display("%0d rejected, %0d ran the pools dry, %0d beats, up to %0d pools per booking",
               rejects, dry_runs, beats_seen, widest);
      if (errors == 0)
         $display("** best_fit_capacity_allocator_core: PASSED **");
      else
         $display("** best_fit_capacity_allocator_core: FAILED **");
      $finish;
   end

endmodule
